@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_ALWAYS_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cfpi_pkg.sv @@
// Package with the types, constants and helpers of the complex float to int16 converter.
`timescale 1ns / 1ps
`default_nettype none
package cfpi_pkg;

  localparam int FLT_W   = 32;
  localparam int MANT_W  = 24;
  localparam int EXP_W   = 11;
  localparam int LZ_W    = 5;
  localparam int I16_W   = 16;
  localparam int STAGES  = 4;

  localparam logic [FLT_W-1:0] SCALE_RESET = 32'h46FF_FE00;
  localparam logic             ORDER_RESET = 1'b0;

  localparam logic [I16_W-1:0] I16_MIN = 16'h8000;
  localparam logic [I16_W-1:0] I16_MAX = 16'h7FFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SCALE = 1'b0,
    CFG_ORDER = 1'b1
  } cfg_idx_t;

  // Stage enables from the top level to the lanes.
  typedef struct packed {
    logic [STAGES-1:0] en;
  } lane_ctl_t;

  // Number of leading zeros of a 24-bit significand (24 when zero).
  function automatic logic [LZ_W-1:0] lzc24(input logic [MANT_W-1:0] m);
    logic [LZ_W-1:0] n;
    logic            found;
    n     = '0;
    found = 1'b0;
    for (int k = MANT_W - 1; k >= 0; k--) begin
      if (!found) begin
        if (m[k]) begin
          found = 1'b1;
        end else begin
          n = n + 1'b1;
        end
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/cfpi_lane.sv @@
// One conversion lane: normalize, multiply, round to float32, convert and saturate to int16.
`timescale 1ns / 1ps
`default_nettype none
module cfpi_lane (
  input  wire logic                      clk,
  input  wire cfpi_pkg::lane_ctl_t       ctl,
  input  wire logic [cfpi_pkg::FLT_W-1:0] x_bits,
  input  wire logic [cfpi_pkg::FLT_W-1:0] s_bits,
  output logic      [cfpi_pkg::I16_W-1:0] result
);
  import cfpi_pkg::*;

  // Stage 1 signals.
  logic [7:0]        xe, se;
  logic [MANT_W-1:0] xm, sm;
  logic [LZ_W-1:0]   xlz, slz;
  logic [7:0]        xe_eff, se_eff;
  logic [MANT_W-1:0] mx_r, ms_r;
  logic signed [EXP_W-1:0] ex_r, es_r;
  logic              sgn1_r, spc1_r, zero1_r;

  // Stage 2 signals.
  logic [2*MANT_W-1:0]     prod_r;
  logic signed [EXP_W-1:0] e2_r;
  logic                    sgn2_r, spc2_r, zero2_r;

  // Stage 3 signals.
  logic                    top;
  logic [MANT_W-1:0]       f24;
  logic                    rb3, st3, inc3;
  logic [MANT_W:0]         sum3;
  logic [MANT_W-1:0]       f_r;
  logic signed [EXP_W-1:0] ef_r;
  logic                    sgn3_r, spc3_r, zero3_r;

  // Stage 4 signals.
  logic signed [EXP_W-1:0] nef;
  logic [LZ_W-1:0]         sh;
  logic [2*MANT_W-1:0]     shifted;
  logic [MANT_W-1:0]       q4;
  logic                    rb4, st4;
  logic [MANT_W:0]         mag;
  logic [I16_W-1:0]        res_nxt;
  logic [I16_W-1:0]        res_r;

  // Unpack both operands and normalize subnormal significands.
  always_comb begin
    xe     = x_bits[30:23];
    se     = s_bits[30:23];
    xm     = {(xe != 8'd0), x_bits[22:0]};
    sm     = {(se != 8'd0), s_bits[22:0]};
    xe_eff = (xe == 8'd0) ? 8'd1 : xe;
    se_eff = (se == 8'd0) ? 8'd1 : se;
    xlz    = lzc24(xm);
    slz    = lzc24(sm);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      mx_r    <= xm << xlz;
      ms_r    <= sm << slz;
      ex_r    <= $signed({3'b000, xe_eff}) - $signed({6'b000000, xlz});
      es_r    <= $signed({3'b000, se_eff}) - $signed({6'b000000, slz});
      sgn1_r  <= x_bits[31] ^ s_bits[31];
      spc1_r  <= (xe == 8'hFF) || (se == 8'hFF);
      zero1_r <= (xm == '0) || (sm == '0);
    end
  end

  // Significand product; value is prod * 2^(ex + es - 300).
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      prod_r  <= mx_r * ms_r;
      e2_r    <= ex_r + es_r - EXP_W'(300);
      sgn2_r  <= sgn1_r;
      spc2_r  <= spc1_r;
      zero2_r <= zero1_r;
    end
  end

  // Round the product to a 24-bit significand, nearest even.
  always_comb begin
    top  = prod_r[2*MANT_W-1];
    f24  = top ? prod_r[47:24] : prod_r[46:23];
    rb3  = top ? prod_r[23] : prod_r[22];
    st3  = top ? (|prod_r[22:0]) : (|prod_r[21:0]);
    inc3 = rb3 & (st3 | f24[0]);
    sum3 = {1'b0, f24} + {{MANT_W{1'b0}}, inc3};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      f_r     <= sum3[MANT_W] ? {1'b1, {(MANT_W-1){1'b0}}} : sum3[MANT_W-1:0];
      ef_r    <= e2_r + (top ? EXP_W'(24) : EXP_W'(23))
                 + {{(EXP_W-1){1'b0}}, sum3[MANT_W]};
      sgn3_r  <= sgn2_r;
      spc3_r  <= spc2_r;
      zero3_r <= zero2_r;
    end
  end

  // Convert the float32 value f * 2^ef to an integer, nearest even, and saturate.
  always_comb begin
    nef     = -ef_r;
    sh      = nef[LZ_W-1:0];
    shifted = {f_r, {MANT_W{1'b0}}} >> sh;
    q4      = shifted[47:24];
    rb4     = shifted[23];
    st4     = |shifted[22:0];
    mag     = {1'b0, q4} + {{MANT_W{1'b0}}, rb4 & (st4 | q4[0])};
    if (spc3_r) begin
      res_nxt = I16_MIN;
    end else if (zero3_r) begin
      res_nxt = '0;
    end else if (ef_r >= EXP_W'(8)) begin
      res_nxt = I16_MIN;
    end else if (ef_r >= EXP_W'(0)) begin
      res_nxt = sgn3_r ? I16_MIN : I16_MAX;
    end else if (nef > EXP_W'(24)) begin
      res_nxt = '0;
    end else if (!sgn3_r) begin
      res_nxt = (mag > 25'd32767) ? I16_MAX : mag[I16_W-1:0];
    end else begin
      res_nxt = (mag >= 25'd32768) ? I16_MIN : (~mag[I16_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule
`default_nettype wire

@@ sv/cfpi_merge.sv @@
// Merging stage: packs both lanes into one word in the configured byte order.
`timescale 1ns / 1ps
`default_nettype none
module cfpi_merge (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic                       big_endian,
  input  wire logic [cfpi_pkg::I16_W-1:0] i_val,
  input  wire logic [cfpi_pkg::I16_W-1:0] q_val,
  output logic      [cfpi_pkg::FLT_W-1:0] word
);
  import cfpi_pkg::*;

  logic [FLT_W-1:0] w;
  logic [FLT_W-1:0] word_r;

  // I in the high half, Q in the low half; reverse bytes for big-endian.
  always_comb begin
    w = {i_val, q_val};
    if (big_endian) begin
      w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= w;
    end
  end

  assign word = word_r;

endmodule
`default_nettype wire

@@ sv/complex_float_to_packed_int16.sv @@
// Top level of the complex float32 to packed int16 converter.
//
//   channel  | dir | payload
//   in_*     | in  | tdata[31:0] I bits, tdata[63:32] Q bits, tlast
//   out_*    | out | tdata[31:0] packed word, tlast
//   cfg_*    | in  | index 0 scale bits, index 1 byte order
//
// One sample is accepted per clock while the output is not stalled; out_tvalid rises once the
// sample has passed the lane registers (normalize, multiply, round, convert) and the merge register.
// Reset is synchronous and active low; it empties the pipeline and loads default registers.
// A stall on the output holds the pipeline; empty stages still take new samples.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module complex_float_to_packed_int16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] in_phase_bits, [63:32] quadrature_bits
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] packed_word
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire cfpi_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import cfpi_pkg::*;

  logic [FLT_W-1:0]  scale_r;
  logic              order_r;
  logic [STAGES:0]   vld_r;
  logic [STAGES:0]   last_r;
  logic [STAGES:0]   en;
  lane_ctl_t         ctl;
  logic [I16_W-1:0]  i_res, q_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE: scale_r <= cfg_wdata;
        CFG_ORDER: order_r <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[STAGES] = !vld_r[STAGES] || out_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    ctl.en = en[STAGES-1:0];
  end

  assign in_tready = en[0];

  // Valid and last markers travel beside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last_r[0] <= in_tlast;
    end
    for (int k = 1; k <= STAGES; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  cfpi_lane u_lane_i (
    .clk    (clk),
    .ctl    (ctl),
    .x_bits (in_tdata[31:0]),
    .s_bits (scale_r),
    .result (i_res)
  );

  cfpi_lane u_lane_q (
    .clk    (clk),
    .ctl    (ctl),
    .x_bits (in_tdata[63:32]),
    .s_bits (scale_r),
    .result (q_res)
  );

  cfpi_merge u_merge (
    .clk        (clk),
    .en         (en[STAGES]),
    .big_endian (order_r),
    .i_val      (i_res),
    .q_val      (q_res),
    .word       (out_tdata)
  );

  assign out_tvalid = vld_r[STAGES];
  assign out_tlast  = last_r[STAGES];

  // A ready output side never blocks the input.
  `ASSERT_IMP(a_ready_flow, out_tready, in_tready)
  // A full pipeline under output stall takes no transfer.
  `ASSERT_IMP(a_full_stall, (&vld_r) && !out_tready, !in_tready)
  // An accepted transfer occupies the first stage.
  `ASSERT_NXT(a_accept_fill, in_tvalid && in_tready, vld_r[0])
  // Reset leaves no result on the output.
  `ASSERT_ALWAYS_NXT(a_reset_empty, !rst_n, !out_tvalid)

endmodule
`default_nettype wire

@@ verif/complex_float_to_packed_int16_tb.sv @@
// Self-checking testbench for the complex float32 to packed int16 converter.
`timescale 1ns / 1ps
`default_nettype none
module complex_float_to_packed_int16_tb;
  import cfpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int LONG_HOLD      = 150;

  // Float32 bit patterns used by the directed tests.
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_HALF     = 32'h3F00_0000;
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } sample_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] in_phase_bits, [63:32] quadrature_bits
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] packed_word
  logic        out_tlast;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [31:0] scale_shadow;
  logic        big_endian_shadow;

  sample_result_t pending_words[$];
  int unsigned    error_count;
  int unsigned    quiet_cycles;
  bit             gaps_on;
  bit             long_hold_req;

  complex_float_to_packed_int16 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shift right with round to nearest even; sh is at least one.
  function automatic logic [63:0] shift_rne(input logic [63:0] v, input int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  // Scales one part, rounds to float32, converts to int and saturates to int16.
  function automatic logic [15:0] part_to_i16(input logic [31:0] xb, input logic [31:0] sb);
    logic [63:0] mag;
    logic [63:0] ival;
    logic [23:0] mx;
    logic [23:0] ms;
    int          ex;
    int          es;
    int          e;
    int          msb_len;
    logic        neg;
    if (xb[30:23] == 8'hFF || sb[30:23] == 8'hFF) begin
      return I16_MIN;
    end
    mx  = (xb[30:23] == 8'd0) ? {1'b0, xb[22:0]} : {1'b1, xb[22:0]};
    ms  = (sb[30:23] == 8'd0) ? {1'b0, sb[22:0]} : {1'b1, sb[22:0]};
    ex  = (xb[30:23] == 8'd0) ? 1 : int'(xb[30:23]);
    es  = (sb[30:23] == 8'd0) ? 1 : int'(sb[30:23]);
    e   = ex + es - 300;
    neg = xb[31] ^ sb[31];
    mag = 64'(mx) * 64'(ms);
    if (mag == 64'd0) begin
      return 16'h0000;
    end
    msb_len = 0;
    for (int k = 0; k < 64; k++) begin
      if (mag[k]) begin
        msb_len = k + 1;
      end
    end
    // Magnitude 2^32 or more overflows before rounding.
    if (msb_len - 1 + e >= 32) begin
      return I16_MIN;
    end
    // Below a quarter every rounding ends at zero.
    if (msb_len - 1 + e < -2) begin
      return 16'h0000;
    end
    // Round the product to a 24-bit significand.
    if (msb_len > 24) begin
      mag = shift_rne(mag, msb_len - 24);
      e   = e + msb_len - 24;
    end
    // Conversion to int32 with round to nearest even.
    if (e >= 0) begin
      ival = mag << e;
    end else begin
      ival = shift_rne(mag, -e);
    end
    if (ival >= 64'h8000_0000) begin
      return I16_MIN;
    end
    if (!neg && ival > 64'd32767) begin
      return I16_MAX;
    end
    if (neg && ival > 64'd32768) begin
      return I16_MIN;
    end
    return neg ? 16'(-ival) : 16'(ival);
  endfunction

  function automatic sample_result_t predict_sample(input logic [31:0] ib,
                                                   input logic [31:0] qb,
                                                   input logic last);
    sample_result_t r;
    logic [31:0]    w;
    w = {part_to_i16(ib, scale_shadow), part_to_i16(qb, scale_shadow)};
    if (big_endian_shadow) begin
      w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    end
    r.word = w;
    r.last = last;
    return r;
  endfunction

  // Random float: half of them near unity range, the rest any bit pattern.
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      f[30:23] = 8'($urandom_range(100, 131));
    end
    return f;
  endfunction

  // Sends one sample and records its expected word on transfer.
  task automatic send_sample(input logic [31:0] ib, input logic [31:0] qb, input logic last);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {qb, ib};
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_words.push_back(predict_sample(ib, qb, last));
  endtask

  // Waits until every expected word has come and the pipeline is empty.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_SCALE) begin
      scale_shadow = value;
    end else begin
      big_endian_shadow = value[0];
    end
  endtask

  task automatic test_default_scale();
    send_sample(F_ONE, 32'hBF80_0000, 1'b0);
    send_sample(F_HALF, 32'h0000_0000, 1'b0);
    send_sample(F_NEG_ZERO, 32'h0000_0001, 1'b0);
    send_sample(32'h4000_0000, 32'hC000_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_special_values();
    send_sample(F_POS_INF, F_NEG_INF, 1'b0);
    send_sample(F_QNAN, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1);
    send_sample(32'h4F00_0000, 32'h3400_0000, 1'b0);
    wait_drained();
  endtask

  // Unit scale exposes the ties of the integer rounding and the int32 limits.
  task automatic test_rounding_ties();
    write_reg(CFG_SCALE, F_ONE);
    send_sample(32'h4020_0000, 32'h4060_0000, 1'b0);  // 2.5 and 3.5
    send_sample(32'hC020_0000, 32'hC060_0000, 1'b0);  // -2.5 and -3.5
    send_sample(F_HALF, 32'h3FC0_0000, 1'b0);         // 0.5 and 1.5
    send_sample(32'h46FF_FE00, 32'hC700_0000, 1'b0);  // 32767 and -32768
    send_sample(32'h4700_0000, 32'hC700_0100, 1'b0);  // 32768 and -32769
    send_sample(32'h4EFF_FFFF, 32'hCF00_0000, 1'b1);  // near and at 2^31
    wait_drained();
  endtask

  task automatic test_byte_order();
    write_reg(CFG_ORDER, 32'h0000_0001);
    write_reg(CFG_SCALE, 32'h46FF_FE00);
    send_sample(32'h3E80_0000, 32'hBF00_0000, 1'b1);
    send_sample(F_QNAN, F_ONE, 1'b0);
    wait_drained();
    write_reg(CFG_ORDER, 32'h0000_0000);
  endtask

  task automatic test_scale_extremes();
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    send_sample(F_ONE, 32'h0000_0000, 1'b0);
    wait_drained();
    write_reg(CFG_SCALE, 32'h0000_0000);
    send_sample(32'h7F7F_FFFF, F_NEG_ZERO, 1'b1);
    wait_drained();
    write_reg(CFG_SCALE, 32'h0000_0001);
    send_sample(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering samples.
  task automatic test_backpressure();
    write_reg(CFG_SCALE, 32'h4500_0000);
    long_hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_sample(rand_float(), rand_float(), n[2]);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [31:0] scale_pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: scale_pick = 32'h46FF_FE00;
        1: scale_pick = F_ONE;
        2: scale_pick = 32'hC6FF_FE00;
        3: scale_pick = $urandom;
        default: scale_pick = {$urandom_range(0, 1) == 1,
                               8'($urandom_range(110, 150)), 23'($urandom)};
      endcase
      gaps_on = (phase < 7);
      write_reg(CFG_SCALE, scale_pick);
      write_reg(CFG_ORDER, 32'($urandom_range(0, 1)));
      for (int n = 0; n < 150; n++) begin
        send_sample(rand_float(), rand_float(), 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end
  endtask

  // Receiver ready pattern: random holds, one long hold on request.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Output checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h last %b", $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        if (out_tdata !== pending_words[0].word) begin
          $display("%0t: word mismatch expected %h actual %h", $time,
                   pending_words[0].word, out_tdata);
          error_count++;
        end
        if (out_tlast !== pending_words[0].last) begin
          $display("%0t: last mismatch expected %b actual %b", $time,
                   pending_words[0].last, out_tlast);
          error_count++;
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tlast          = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SCALE;
    cfg_wdata         = '0;
    error_count       = 0;
    quiet_cycles      = 0;
    gaps_on           = 1'b1;
    long_hold_req     = 1'b0;
    scale_shadow      = SCALE_RESET;
    big_endian_shadow = ORDER_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_scale();
    test_special_values();
    test_rounding_ties();
    test_byte_order();
    test_scale_extremes();
    test_backpressure();
    test_random_phases();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
